>>> design/sdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdq_pkg;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic signed [31:0] key;
        logic        [15:0] tag;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_RDOUT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> design/sorted_insert_depth_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sorted list of (tag, depth key) entries, kept in one entry memory
// a request is taken when start is high and busy is low; func selects
// push, read at rank or clear; i_cfg_we writes the sort order bit (0
// ascending, 1 descending), which the user must do only while no request
// is in flight, as the block does not enforce it; each request gives one
// result on the o_ ports, marked by o_strobe for a single cycle; the
// receiver cannot stall, so the result is never held; push: the memory
// is swept from the front, one position per cycle, reading ahead of a
// ripple of writes that moves every entry behind the insertion point back
// by one; busy stays high through the sweep and the tail write, and the
// result follows in the next cycle; read at a valid rank: one memory
// read, busy in the read-out state, result after it; clear, full push,
// bad rank and the unused code: busy stays low, result in the cycle after
// the request; reset empties the list and sets ascending order; entry
// contents are not cleared, an entry is only read below the held count
module sorted_insert_depth_queue_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic [1:0]         i_func,
    input  wire logic [15:0]        i_entry_tag,
    input  wire logic signed [31:0] i_depth_key,
    input  wire logic [5:0]         i_read_rank,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [15:0]             o_out_tag,
    output logic signed [31:0]      o_out_depth,
    output logic [6:0]              o_entry_count
);
    import sdq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    t_entry        r_rdata;
    t_entry        r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (mem_ctl.wr_en) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_ctl.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    sdq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_func),
        .i_entry_tag   (i_entry_tag),
        .i_depth_key   (i_depth_key),
        .i_read_rank   (i_read_rank),
        .o_mem_ctl     (mem_ctl),
        .o_raddr       (raddr),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .i_rdata       (r_rdata),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_out_tag     (o_out_tag),
        .o_out_depth   (o_out_depth),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

>>> design/sdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sdq_ctrl #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    input  wire logic [1:0]                     i_func,
    input  wire logic [15:0]                    i_entry_tag,
    input  wire logic signed [31:0]             i_depth_key,
    input  wire logic [5:0]                     i_read_rank,
    output sdq_pkg::t_mem_ctl                   o_mem_ctl,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      o_raddr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      o_waddr,
    output sdq_pkg::t_entry                     o_wdata,
    input  wire sdq_pkg::t_entry                i_rdata,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [15:0]                         o_out_tag,
    output logic signed [31:0]                  o_out_depth,
    output logic [6:0]                          o_entry_count
);
    import sdq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = CW + 6;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_order, n_order;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_vld, n_vld;
    logic [AW-1:0]      r_pos, n_pos;
    t_entry             r_carry, n_carry;
    logic               r_carrying, n_carrying;
    t_entry             r_new, n_new;
    logic               r_strobe, n_strobe;
    logic [1:0]         r_status, n_status;
    logic [15:0]        r_tag, n_tag;
    logic signed [31:0] r_depth, n_depth;
    logic [6:0]         r_cnt_out, n_cnt_out;

    logic               accept;
    logic               issue;
    logic               passes;
    logic               full;
    logic               rank_ok;
    logic [RW-1:0]      rank_wide;

    assign accept    = start && (r_state == S_IDLE);
    assign issue     = (r_ptr != r_count);
    assign full      = (r_count >= CW'(QUEUE_DEPTH));
    assign rank_wide = RW'(i_read_rank);
    assign rank_ok   = (rank_wide < RW'(r_count));
    // first stored entry that the new key passes under the current order
    assign passes    = r_order ? (i_rdata.key < r_new.key) : (r_new.key < i_rdata.key);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_PUSH && !full) begin
                        n_state = S_SCAN;
                    end else if (i_func == FUNC_READ && rank_ok) begin
                        n_state = S_RDOUT;
                    end
                end
            end
            S_SCAN: begin
                // the last read entry is handled in this same cycle
                if (!issue) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL:  n_state = S_IDLE;
            S_RDOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mem_ctl  = '0;
        o_raddr    = '0;
        o_waddr    = r_pos;
        o_wdata    = r_carry;
        n_count    = r_count;
        n_order    = i_cfg_we ? i_cfg_wdata : r_order;
        n_ptr      = r_ptr;
        n_vld      = 1'b0;
        n_pos      = r_pos;
        n_carry    = r_carry;
        n_carrying = r_carrying;
        n_new      = r_new;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_tag      = r_tag;
        n_depth    = r_depth;
        n_cnt_out  = r_cnt_out;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tag     = '0;
                    n_depth   = '0;
                    n_status  = STAT_OK;
                    n_cnt_out = 7'(r_count);
                    priority if (i_func == FUNC_PUSH) begin
                        if (full) begin
                            n_strobe = 1'b1;
                            n_status = STAT_FULL;
                        end else begin
                            n_new      = '{key: i_depth_key, tag: i_entry_tag};
                            n_ptr      = '0;
                            n_carrying = 1'b0;
                        end
                    end else if (i_func == FUNC_READ) begin
                        if (rank_ok) begin
                            o_mem_ctl.rd_en = 1'b1;
                            o_raddr         = AW'(rank_wide);
                        end else begin
                            n_strobe = 1'b1;
                            n_status = STAT_RANGE;
                        end
                    end else if (i_func == FUNC_CLEAR) begin
                        n_count   = '0;
                        n_cnt_out = '0;
                        n_strobe  = 1'b1;
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // reads run one position ahead of the ripple writes
                if (issue) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = AW'(r_ptr);
                    n_ptr           = r_ptr + 1'b1;
                    n_vld           = 1'b1;
                    n_pos           = AW'(r_ptr);
                end
                if (r_vld) begin
                    if (r_carrying) begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_wdata         = r_carry;
                        n_carry         = i_rdata;
                    end else if (passes) begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_wdata         = r_new;
                        n_carry         = i_rdata;
                        n_carrying      = 1'b1;
                    end
                end
            end
            S_TAIL: begin
                // last displaced entry, or the new one, lands at the end
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = AW'(r_count);
                o_wdata         = r_carrying ? r_carry : r_new;
                n_count         = r_count + 1'b1;
                n_cnt_out       = 7'(r_count + 1'b1);
                n_strobe        = 1'b1;
            end
            S_RDOUT: begin
                n_strobe = 1'b1;
                n_tag    = i_rdata.tag;
                n_depth  = i_rdata.key;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_order    <= 1'b0;
            r_vld      <= 1'b0;
            r_carrying <= 1'b0;
            r_strobe   <= 1'b0;
            r_ptr      <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_order    <= n_order;
            r_vld      <= n_vld;
            r_carrying <= n_carrying;
            r_strobe   <= n_strobe;
            r_ptr      <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_carry   <= n_carry;
        r_new     <= n_new;
        r_status  <= n_status;
        r_tag     <= n_tag;
        r_depth   <= n_depth;
        r_cnt_out <= n_cnt_out;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_tag     = r_tag;
    assign o_out_depth   = r_depth;
    assign o_entry_count = r_cnt_out;

endmodule

`default_nettype wire

>>> sim/sorted_insert_depth_queue_unit_test.sv
`timescale 1ns / 1ps

module sorted_insert_depth_queue_unit_test;

    import sdq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 106;
    // the package leaves code 3 unnamed; the block must treat it as a no-op
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic [1:0]         i_func = FUNC_PUSH;
    logic [15:0]        i_entry_tag = 16'd0;
    logic signed [31:0] i_depth_key = 32'sd0;
    logic [5:0]         i_read_rank = 6'd0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [15:0]        o_out_tag;
    logic signed [31:0] o_out_depth;
    logic [6:0]         o_entry_count;

    typedef struct {
        logic [1:0]         status;
        logic [15:0]        tag;
        logic signed [31:0] depth;
        logic [6:0]         count;
    } t_reply;

    // mirror of the sorted list and the replies it owes
    class depth_list_mirror;
        logic signed [31:0] keys [QUEUE_DEPTH];
        logic        [15:0] tags [QUEUE_DEPTH];
        int unsigned        held_count;
        logic               descending;
        t_reply             awaited [$];
        int                 errors;

        function new();
            held_count = 0;
            descending = 1'b0;
            errors = 0;
        endfunction

        function void set_order(logic order);
            descending = order;
        endfunction

        function int unsigned held();
            return held_count;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // new key goes in front of the first held key that it passes
        function bit passes(logic signed [31:0] key, logic signed [31:0] held_key);
            return descending ? (held_key < key) : (key < held_key);
        endfunction

        function void note_request(logic [1:0] func, logic [15:0] tag,
                                   logic signed [31:0] key, logic [5:0] rank);
            t_reply      r;
            int unsigned pos;
            int unsigned i;
            r.status = STAT_OK;
            r.tag = 16'd0;
            r.depth = 32'sd0;
            case (func)
                FUNC_PUSH: begin
                    if (held_count >= QUEUE_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held_count && !passes(key, keys[pos])) pos++;
                        for (i = held_count; i > pos; i--) begin
                            keys[i] = keys[i - 1];
                            tags[i] = tags[i - 1];
                        end
                        keys[pos] = key;
                        tags[pos] = tag;
                        held_count++;
                    end
                end
                FUNC_READ: begin
                    if (rank < held_count) begin
                        r.tag = tags[rank];
                        r.depth = keys[rank];
                    end else begin
                        r.status = STAT_RANGE;
                    end
                end
                FUNC_CLEAR: begin
                    held_count = 0;
                end
                default: begin
                end
            endcase
            r.count = held_count[6:0];
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(logic [1:0] status, logic [15:0] tag,
                                   logic signed [31:0] depth, logic [6:0] count);
            t_reply e;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding: status %0d entry_count %0d",
                       status, count);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (tag !== e.tag) begin
                $error("out_tag: expected %0h, got %0h", e.tag, tag);
                errors++;
            end
            if (depth !== e.depth) begin
                $error("out_depth: expected %0d, got %0d", e.depth, depth);
                errors++;
            end
            if (count !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, count);
                errors++;
            end
        endfunction
    endclass

    depth_list_mirror mirror = new();

    int sent_count = 0;
    bit start_held = 1'b0;
    bit no_idle = 1'b0;
    int stall_cycles = 0;

    sorted_insert_depth_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_func(i_func),
        .i_entry_tag(i_entry_tag),
        .i_depth_key(i_depth_key),
        .i_read_rank(i_read_rank),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_out_tag(o_out_tag),
        .o_out_depth(o_out_depth),
        .o_entry_count(o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            mirror.check_result(o_status, o_out_tag, o_out_depth, o_entry_count);
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_strobe === 1'b1) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("** sorted_insert_depth_queue_unit: FAILED **");
        $finish;
    end

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // 0 full range, 1 narrow band with many ties, 2 extremes
    function automatic logic signed [31:0] draw_key(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 6) - 3;
            default: begin
                case ($urandom_range(0, 4))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [5:0] valid_rank();
        if (mirror.held() == 0) return 6'($urandom);
        return 6'($urandom_range(0, mirror.held() - 1));
    endfunction

    // start stays high across back-to-back requests
    task automatic send_request(input logic [1:0] f, input logic [15:0] t,
                                input logic signed [31:0] k, input logic [5:0] r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            if (start_held) start <= 1'b0;
            start_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_entry_tag <= t;
        i_depth_key <= k;
        i_read_rank <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.note_request(f, t, k, r);
        start_held = 1'b1;
        sent_count++;
    endtask

    task automatic release_start();
        if (start_held) start <= 1'b0;
        start_held = 1'b0;
    endtask

    task automatic write_order(input logic order);
        while (mirror.pending() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= order;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.set_order(order);
    endtask

    task automatic run_random_phase(input int goal);
        int kind;
        int mode;
        int len;
        int i;
        while (sent_count < goal) begin
            kind = $urandom_range(0, 9);
            mode = $urandom_range(0, 2);
            if (kind <= 4) begin
                // fill run, sometimes past capacity
                if ($urandom_range(0, 4) == 0) len = QUEUE_DEPTH + 2 - int'(mirror.held());
                else len = $urandom_range(1, 10);
                if (len < 1) len = 1;
                for (i = 0; i < len; i++) begin
                    send_request(FUNC_PUSH, 16'($urandom), draw_key(mode), 6'($urandom));
                end
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    send_request(FUNC_READ, 16'($urandom), $urandom, valid_rank());
                end
            end else if (kind <= 6) begin
                len = $urandom_range(1, 5);
                for (i = 0; i < len; i++) begin
                    send_request(FUNC_READ, 16'($urandom), $urandom, 6'($urandom));
                end
            end else if (kind == 7) begin
                send_request(FUNC_CLEAR, 16'($urandom), $urandom, 6'($urandom));
            end else begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++) begin
                    send_request(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                                 6'($urandom));
                end
            end
        end
        release_start();
    endtask

    initial begin
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_order(1'b0);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd0);
        send_request(FUNC_PUSH, 16'h1234, 32'sd0, 6'd0);
        // equal key lands behind the held one
        send_request(FUNC_PUSH, 16'h5678, 32'sd0, 6'd63);
        send_request(FUNC_PUSH, 16'hffff, KEY_MAX, 6'd0);
        send_request(FUNC_PUSH, 16'h0000, KEY_MIN, 6'd0);
        send_request(FUNC_PUSH, 16'ha5a5, -32'sd1, 6'd0);
        for (p = 0; p < 5; p++) begin
            send_request(FUNC_READ, 16'hffff, KEY_MAX, 6'(p));
        end
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd5);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd63);
        send_request(FUNC_UNUSED, 16'hffff, KEY_MIN, 6'd63);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd0);
        send_request(FUNC_CLEAR, 16'hffff, KEY_MAX, 6'd63);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd0);
        send_request(FUNC_PUSH, 16'h0001, 32'sd1, 6'd0);
        send_request(FUNC_PUSH, 16'h0002, 32'sd3, 6'd0);
        release_start();

        // list still held when the order flips: no re-sort
        write_order(1'b1);
        send_request(FUNC_PUSH, 16'h0003, 32'sd2, 6'd0);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd0);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd1);
        send_request(FUNC_READ, 16'h0000, 32'sd0, 6'd2);
        release_start();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) write_order(1'b1);
            else if (p == 1) write_order(1'b0);
            else write_order(1'($urandom_range(0, 1)));
            run_random_phase(sent_count + PHASE_ITEMS);
        end

        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (QUEUE_DEPTH + 16) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("** sorted_insert_depth_queue_unit: PASSED **");
        end else begin
            $display("** sorted_insert_depth_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
design/sdq_pkg.sv
design/sdq_ctrl.sv
design/sorted_insert_depth_queue_unit.sv
sim/sorted_insert_depth_queue_unit_test.sv
